// ===== src/max_pool_2d_window_top_assert.svh =====
// Assertion macros shared by the max pooling block's checker.
`ifndef MAX_POOL_2D_WINDOW_TOP_ASSERT_SVH
`define MAX_POOL_2D_WINDOW_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MP2D_ASSERT_IMPLY(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MP2D_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

// ===== src/mp2d_pkg.sv =====
// Shared types, widths and constants of the max pooling block.
`timescale 1ns / 1ps
package mp2d_pkg;

  // Default sizes of the sample store and window
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_KERNEL = 8;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int DIM_W      = 7;
  localparam int KSZ_W      = 4;
  localparam int STR_W      = 4;
  localparam int PAD_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int DIM_CMP_W  = 11;
  localparam int PROD_W     = DIM_W + STR_W;
  localparam int COORD_W    = PROD_W + 2;

  // Register reset values
  localparam logic [KSZ_W-1:0] KSZ_RST = KSZ_W'(2);
  localparam logic [STR_W-1:0] STR_RST = STR_W'(2);
  localparam logic [PAD_W-1:0] PAD_RST = PAD_W'(0);
  localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(64);

  // Window maximum starts at the most negative sample
  localparam logic signed [SAMPLE_W-1:0] ACC_START = 16'sh8000;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL  = 3'd0,
    REG_STRIDE  = 3'd1,
    REG_PADDING = 3'd2,
    REG_WIDTH   = 3'd3,
    REG_HEIGHT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_FIN  = 3'b100
  } back_state_t;

  // One classified item; a write carries its row and column in y0 and x0
  typedef struct packed {
    logic                        is_query;
    logic signed [COORD_W-1:0]   y0;
    logic signed [COORD_W-1:0]   x0;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [KSZ_W-1:0]            k;
    logic [DIM_W-1:0]            h;
    logic [DIM_W-1:0]            w;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/mp2d_front.sv =====
// Front end: configuration registers, item intake and classification.
`timescale 1ns / 1ps
module mp2d_front
  import mp2d_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_opcode,
  input  logic [DIM_W-1:0]           in_row,
  input  logic [DIM_W-1:0]           in_col,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output logic                       push,
  output q_entry_t                   push_entry,
  input  q_stat_t                    q_stat
);

  logic [KSZ_W-1:0] kernel_r, kernel_nxt;
  logic [STR_W-1:0] stride_r, stride_nxt;
  logic [PAD_W-1:0] padding_r, padding_nxt;
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;

  q_entry_t ent_r, ent_nxt;
  logic     ent_vld_r, ent_vld_nxt;

  logic                      accept;
  logic [DIM_W-1:0]          eff_w, eff_h;
  logic [KSZ_W-1:0]          eff_k;
  logic [PROD_W-1:0]         prod_y, prod_x;
  logic signed [COORD_W-1:0] qy0, qx0;
  logic                      wr_in_plane;

  assign cfg_ready = 1'b1;

  // Register writes
  always_comb begin
    kernel_nxt  = kernel_r;
    stride_nxt  = stride_r;
    padding_nxt = padding_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KERNEL:  kernel_nxt  = cfg_data[KSZ_W-1:0];
        REG_STRIDE:  stride_nxt  = cfg_data[STR_W-1:0];
        REG_PADDING: padding_nxt = cfg_data[PAD_W-1:0];
        REG_WIDTH:   width_nxt   = cfg_data[DIM_W-1:0];
        REG_HEIGHT:  height_nxt  = cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry clamped to the store and window limits
  assign eff_w = (DIM_CMP_W'(width_r) > DIM_CMP_W'(MAX_WIDTH)) ?
                 DIM_W'(MAX_WIDTH) : width_r;
  assign eff_h = (DIM_CMP_W'(height_r) > DIM_CMP_W'(MAX_HEIGHT)) ?
                 DIM_W'(MAX_HEIGHT) : height_r;
  assign eff_k = ((KSZ_W + 1)'(kernel_r) > (KSZ_W + 1)'(MAX_KERNEL)) ?
                 KSZ_W'(MAX_KERNEL) : kernel_r;

  // Window corner: coordinate times stride minus padding
  assign prod_y = PROD_W'(in_row) * PROD_W'(stride_r);
  assign prod_x = PROD_W'(in_col) * PROD_W'(stride_r);
  assign qy0 = $signed(COORD_W'(prod_y)) - $signed(COORD_W'(padding_r));
  assign qx0 = $signed(COORD_W'(prod_x)) - $signed(COORD_W'(padding_r));

  assign wr_in_plane = (in_row < eff_h) && (in_col < eff_w);

  // Intake register, drained into the queue
  assign busy       = ent_vld_r & q_stat.full;
  assign accept     = start & ~busy;
  assign push       = ent_vld_r & ~q_stat.full;
  assign push_entry = ent_r;

  always_comb begin
    ent_nxt     = ent_r;
    ent_vld_nxt = ent_vld_r;
    if (push) begin
      ent_vld_nxt = 1'b0;
    end
    if (accept) begin
      ent_nxt.is_query = (op_t'(in_opcode) == OP_QUERY);
      ent_nxt.sample   = in_sample;
      ent_nxt.k        = eff_k;
      ent_nxt.h        = eff_h;
      ent_nxt.w        = eff_w;
      if (op_t'(in_opcode) == OP_QUERY) begin
        ent_nxt.y0  = qy0;
        ent_nxt.x0  = qx0;
        ent_vld_nxt = 1'b1;
      end else begin
        ent_nxt.y0  = COORD_W'(in_row);
        ent_nxt.x0  = COORD_W'(in_col);
        ent_vld_nxt = wr_in_plane;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r  <= KSZ_RST;
      stride_r  <= STR_RST;
      padding_r <= PAD_RST;
      width_r   <= DIM_RST;
      height_r  <= DIM_RST;
      ent_vld_r <= 1'b0;
    end else begin
      kernel_r  <= kernel_nxt;
      stride_r  <= stride_nxt;
      padding_r <= padding_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      ent_vld_r <= ent_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== src/mp2d_fifo.sv =====
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
module mp2d_fifo
  import mp2d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  stat
);

  q_entry_t           slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== src/mp2d_back.sv =====
// Back end: sample store, window scan and result strobe.
`timescale 1ns / 1ps
module mp2d_back
  import mp2d_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  q_entry_t                   head,
  input  q_stat_t                    q_stat,
  output logic                       pop,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_max_value
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [SAMPLE_W-1:0] plane_mem [DEPTH];

  back_state_t                state_r, state_nxt;
  q_entry_t                   cur_r, cur_nxt;
  logic [KSZ_W-1:0]           dy_r, dy_nxt, dx_r, dx_nxt;
  logic signed [SAMPLE_W-1:0] best_r, best_nxt;
  logic                       pend_vld_r, pend_vld_nxt;
  logic                       pend_in_r, pend_in_nxt;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_val_r, out_val_nxt;

  logic                       in_idle;
  logic signed [COORD_W-1:0]  base_y, base_x, ty, tx;
  logic [KSZ_W-1:0]           off_y, off_x, k_m1;
  logic [DIM_W-1:0]           h_sel, w_sel;
  logic                       tap_in;
  logic [AW-1:0]              addr;
  logic                       mem_we;
  logic signed [SAMPLE_W-1:0] cand, best_fold;

  assign in_idle = (state_r == B_IDLE);
  assign k_m1    = KSZ_W'(cur_r.k - 1'b1);

  // Position under the scan: head entry when idle, window tap otherwise
  assign base_y = in_idle ? head.y0 : cur_r.y0;
  assign base_x = in_idle ? head.x0 : cur_r.x0;
  assign off_y  = in_idle ? '0 : dy_r;
  assign off_x  = in_idle ? '0 : dx_r;
  assign h_sel  = in_idle ? head.h : cur_r.h;
  assign w_sel  = in_idle ? head.w : cur_r.w;
  assign ty     = base_y + $signed(COORD_W'(off_y));
  assign tx     = base_x + $signed(COORD_W'(off_x));
  assign tap_in = !ty[COORD_W-1] && !tx[COORD_W-1] &&
                  (ty[COORD_W-2:0] < (COORD_W - 1)'(h_sel)) &&
                  (tx[COORD_W-2:0] < (COORD_W - 1)'(w_sel));
  assign addr   = tap_in ? AW'(32'(ty[COORD_W-2:0]) * 32'(MAX_WIDTH) +
                               32'(tx[COORD_W-2:0])) : '0;

  // Fold the sample read last cycle; padding reads as zero
  assign cand      = pend_in_r ? rd_data_r : '0;
  assign best_fold = (pend_vld_r && (cand > best_r)) ? cand : best_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    dy_nxt        = dy_r;
    dx_nxt        = dx_r;
    best_nxt      = best_r;
    pend_vld_nxt  = 1'b0;
    pend_in_nxt   = pend_in_r;
    out_valid_nxt = 1'b0;
    out_val_nxt   = out_val_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (head.is_query) begin
            cur_nxt   = head;
            dy_nxt    = '0;
            dx_nxt    = '0;
            best_nxt  = ACC_START;
            state_nxt = (head.k == '0) ? B_FIN : B_SCAN;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      B_SCAN: begin
        pend_vld_nxt = 1'b1;
        pend_in_nxt  = tap_in;
        best_nxt     = best_fold;
        if (dx_r == k_m1) begin
          dx_nxt = '0;
          if (dy_r == k_m1) begin
            state_nxt = B_FIN;
          end else begin
            dy_nxt = dy_r + 1'b1;
          end
        end else begin
          dx_nxt = dx_r + 1'b1;
        end
      end
      B_FIN: begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = best_fold;
        state_nxt     = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    dy_r      <= dy_nxt;
    dx_r      <= dx_nxt;
    best_r    <= best_nxt;
    pend_in_r <= pend_in_nxt;
    out_val_r <= out_val_nxt;
  end

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      plane_mem[addr] <= head.sample;
    end
    rd_data_r <= plane_mem[addr];
  end

  assign out_valid     = out_valid_r;
  assign out_max_value = out_val_r;

endmodule

// ===== src/max_pool_2d_window_top.sv =====
// Top level of the 2-D max pooling block over one on-chip sample plane.
// Items are taken when start is high and busy is low. A write (opcode 0)
// stores a 16-bit signed sample at (row, col) if it lies inside the
// configured plane and gives no result. A query (opcode 1) reads K
// squared samples, K being the window side, through the single read
// port of the sample store, one per cycle, and holds the back end while
// it does so. Window taps outside the plane count as zero.
// An intake register and a four-entry queue let the caller keep issuing
// items while a query runs; busy rises only when both are full. Each
// result appears on out_max_value for exactly one cycle with out_valid
// high, in item order; there is no way to hold it off, so the receiver
// must take it then. The sample store is not cleared by reset: a query
// must only cover positions written since reset. Configuration writes are
// always ready and must only be issued while no item is in flight.
`timescale 1ns / 1ps
module max_pool_2d_window_top
  import mp2d_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_opcode,
  input  logic [DIM_W-1:0]           in_row,
  input  logic [DIM_W-1:0]           in_col,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_max_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  logic     push, pop;
  q_entry_t push_entry, head;
  q_stat_t  q_stat;

  mp2d_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_opcode  (in_opcode),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_sample  (in_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_entry (push_entry),
    .q_stat     (q_stat)
  );

  mp2d_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  mp2d_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_max_value (out_max_value)
  );

endmodule

// ===== src/mp2d_checker.sv =====
// Port-level checks of the max pooling block, bound to its top level.
`timescale 1ns / 1ps
`include "max_pool_2d_window_top_assert.svh"
module mp2d_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  // After a strobe the back end returns to idle before the next result, so strobes never abut
  `MP2D_ASSERT_NEXT(a_strobe_gap, out_valid, !out_valid, "back-to-back result strobes")

  // Intake register and queue come out of reset empty
  `MP2D_ASSERT_IMPLY(a_idle_after_rst, !$past(rst_n), !busy, "busy right after reset")

  // Register writes are never held off
  `MP2D_ASSERT_IMPLY(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind max_pool_2d_window_top mp2d_checker u_mp2d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ===== sim/tb_max_pool_2d_window_top.sv =====
// Self-checking testbench for the 2-D max pooling block: sample writes and window queries.
`timescale 1ns / 1ps
module tb_max_pool_2d_window_top;
  import mp2d_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 13;
  localparam int STEADY_PHASE = 7;
  localparam int DIM_MAX      = (1 << DIM_W) - 1;
  localparam int STORE_DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  // Mirror of the sample plane and registers; holds the window maxima still owed
  class pool_scoreboard;
    logic signed [SAMPLE_W-1:0] plane [STORE_DEPTH];
    bit                         written [STORE_DEPTH];
    logic [KSZ_W-1:0]           ksz;
    logic [STR_W-1:0]           step;
    logic [PAD_W-1:0]           pad;
    logic [DIM_W-1:0]           cols;
    logic [DIM_W-1:0]           rows;
    logic signed [SAMPLE_W-1:0] owed_max [$];
    int                         errors;

    function new();
      ksz    = KSZ_RST;
      step   = STR_RST;
      pad    = PAD_RST;
      cols   = DIM_RST;
      rows   = DIM_RST;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KERNEL:  ksz  = data[KSZ_W-1:0];
        REG_STRIDE:  step = data[STR_W-1:0];
        REG_PADDING: pad  = data[PAD_W-1:0];
        REG_WIDTH:   cols = data[DIM_W-1:0];
        REG_HEIGHT:  rows = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Oversized settings saturate at the store and window limits
    function int plane_cols();
      if (cols > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return int'(cols);
    endfunction

    function int plane_rows();
      if (rows > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
      return int'(rows);
    endfunction

    function int window_side();
      if (ksz > DEF_MAX_KERNEL) return DEF_MAX_KERNEL;
      return int'(ksz);
    endfunction

    function bit in_plane(int y, int x);
      return y >= 0 && x >= 0 && y < plane_rows() && x < plane_cols();
    endfunction

    // Store addresses inside the plane that the window of (row, col) reads but
    // nothing has written yet
    function void unwritten_taps(int row, int col, ref int addrs[$]);
      int k;
      int y0;
      int x0;
      k  = window_side();
      y0 = row * int'(step) - int'(pad);
      x0 = col * int'(step) - int'(pad);
      addrs.delete();
      for (int dy = 0; dy < k; dy++)
        for (int dx = 0; dx < k; dx++)
          if (in_plane(y0 + dy, x0 + dx) &&
              !written[(y0 + dy) * DEF_MAX_WIDTH + x0 + dx])
            addrs.push_back((y0 + dy) * DEF_MAX_WIDTH + x0 + dx);
    endfunction

    // Apply one accepted item; returns 0 for a write that lands outside the plane
    function bit note_item(op_t op, logic [DIM_W-1:0] row, logic [DIM_W-1:0] col,
                           logic signed [SAMPLE_W-1:0] sample);
      int                         k;
      int                         y0;
      int                         x0;
      int                         addr;
      logic signed [SAMPLE_W-1:0] best;
      logic signed [SAMPLE_W-1:0] tap;
      if (op == OP_WRITE) begin
        if (!in_plane(int'(row), int'(col))) return 0;
        addr          = int'(row) * DEF_MAX_WIDTH + int'(col);
        plane[addr]   = sample;
        written[addr] = 1'b1;
        return 1;
      end
      k    = window_side();
      y0   = int'(row) * int'(step) - int'(pad);
      x0   = int'(col) * int'(step) - int'(pad);
      best = ACC_START;
      // Taps outside the plane read as zero
      for (int dy = 0; dy < k; dy++)
        for (int dx = 0; dx < k; dx++) begin
          if (in_plane(y0 + dy, x0 + dx)) tap = plane[(y0 + dy) * DEF_MAX_WIDTH + x0 + dx];
          else tap = '0;
          if (tap > best) best = tap;
        end
      owed_max.push_back(best);
      return 1;
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (owed_max.size() == 0) begin
        errors++;
        $display("%0t: max_value %0d arrived with no query waiting", $time, got);
        return;
      end
      want = owed_max.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: max_value mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return owed_max.size();
    endfunction
  endclass

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       start         = 1'b0;
  logic                       busy;
  logic                       in_opcode     = 1'b0;
  logic [DIM_W-1:0]           in_row        = '0;
  logic [DIM_W-1:0]           in_col        = '0;
  logic signed [SAMPLE_W-1:0] in_sample     = '0;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_max_value;
  logic                       cfg_valid     = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index     = '0;
  logic [CFG_DATA_W-1:0]      cfg_data      = '0;

  pool_scoreboard board;
  bit             steady;
  int             counted;

  max_pool_2d_window_top i_dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Results cannot be held off: take each one at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_max_value);
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One item transfer, with a random gap in front unless the stretch is steady
  task automatic send_item(op_t op, logic [DIM_W-1:0] row, logic [DIM_W-1:0] col,
                           logic signed [SAMPLE_W-1:0] sample);
    if (!steady && $urandom_range(99) < 24) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start     <= 1'b1;
    in_opcode <= op;
    in_row    <= row;
    in_col    <= col;
    in_sample <= sample;
    do @(posedge clk); while (busy);
    void'(board.note_item(op, row, col, sample));
    counted++;
  endtask

  // Fill any unwritten in-plane taps first, then issue the query
  task automatic query_window(logic [DIM_W-1:0] row, logic [DIM_W-1:0] col);
    int addrs[$];
    board.unwritten_taps(int'(row), int'(col), addrs);
    foreach (addrs[i])
      send_item(OP_WRITE, DIM_W'(addrs[i] / DEF_MAX_WIDTH),
                DIM_W'(addrs[i] % DEF_MAX_WIDTH), rand_sample());
    send_item(OP_QUERY, row, col, rand_sample());
  endtask

  // Wait for every owed result, then let trailing writes retire
  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] k, logic [CFG_DATA_W-1:0] s,
                              logic [CFG_DATA_W-1:0] p, logic [CFG_DATA_W-1:0] w,
                              logic [CFG_DATA_W-1:0] h);
    drain();
    write_reg(REG_KERNEL, k);
    write_reg(REG_STRIDE, s);
    write_reg(REG_PADDING, p);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-plane writes and in-range queries, some anywhere in the field range
  task automatic random_items(int budget);
    int goal;
    int hh;
    int ww;
    int kk;
    int ss;
    int pp;
    int orows;
    int ocols;
    goal = counted + budget;
    hh   = board.plane_rows();
    ww   = board.plane_cols();
    kk   = board.window_side();
    ss   = int'(board.step);
    pp   = int'(board.pad);
    orows = (ss > 0 && hh + 2 * pp >= kk) ? (hh + 2 * pp - kk) / ss + 1 : 2;
    ocols = (ss > 0 && ww + 2 * pp >= kk) ? (ww + 2 * pp - kk) / ss + 1 : 2;
    if (orows > DIM_MAX + 1) orows = DIM_MAX + 1;
    if (ocols > DIM_MAX + 1) ocols = DIM_MAX + 1;
    while (counted < goal) begin
      if ($urandom_range(1) == 0) begin
        if (hh > 0 && ww > 0 && $urandom_range(99) < 85)
          send_item(OP_WRITE, DIM_W'($urandom_range(hh - 1, 0)),
                    DIM_W'($urandom_range(ww - 1, 0)), rand_sample());
        else
          send_item(OP_WRITE, DIM_W'($urandom_range(DIM_MAX, 0)),
                    DIM_W'($urandom_range(DIM_MAX, 0)), rand_sample());
      end else if ($urandom_range(99) < 85) begin
        query_window(DIM_W'($urandom_range(orows - 1, 0)),
                     DIM_W'($urandom_range(ocols - 1, 0)));
      end else begin
        query_window(DIM_W'($urandom_range(DIM_MAX, 0)), DIM_W'($urandom_range(DIM_MAX, 0)));
      end
    end
  endtask

  // Random geometry, small windows mostly, now and then a raw 7-bit value
  function automatic logic [CFG_DATA_W-1:0] rand_reg(int lo, int hi);
    if ($urandom_range(9) == 0) return CFG_DATA_W'($urandom_range(DIM_MAX, 0));
    return CFG_DATA_W'($urandom_range(hi, lo));
  endfunction

  initial begin
    board   = new();
    counted = 0;
    steady  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes in one window, all-negative and all-minimum windows, ignored writes,
    // query far beyond the output size
    send_item(OP_WRITE, 0, 0, 16'sh7FFF);
    send_item(OP_WRITE, 0, 1, 16'sh8000);
    send_item(OP_WRITE, 1, 0, -16'sd1);
    send_item(OP_WRITE, 1, 1, 16'sd0);
    query_window(0, 0);
    send_item(OP_WRITE, 0, 2, 16'sh8000);
    send_item(OP_WRITE, 0, 3, -16'sd5);
    send_item(OP_WRITE, 1, 2, -16'sd100);
    send_item(OP_WRITE, 1, 3, 16'sh8000);
    query_window(0, 1);
    send_item(OP_WRITE, 62, 62, 16'sh8000);
    send_item(OP_WRITE, 62, 63, 16'sh8000);
    send_item(OP_WRITE, 63, 62, 16'sh8000);
    send_item(OP_WRITE, 63, 63, 16'sh8000);
    query_window(31, 31);
    send_item(OP_WRITE, 64, 0, 16'sh1234);
    send_item(OP_WRITE, DIM_MAX, DIM_MAX, 16'sh7FFF);
    send_item(OP_WRITE, 0, 66, 16'sh7FFF);
    query_window(DIM_MAX, DIM_MAX);
    query_window(0, 1);

    // Directed settings first: unit plane, widest window and padding,
    // zero kernel, empty plane with zero stride, all-ones register data
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_config(1, 1, 0, 1, 1);
        1: apply_config(8, 8, 7, 64, 64);
        2: apply_config(0, 3, 2, 20, 12);
        3: apply_config(3, 0, 7, 0, 0);
        4: apply_config(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX);
        default: apply_config(rand_reg(1, 3), rand_reg(1, 4), rand_reg(0, 3),
                              rand_reg(1, 64), rand_reg(1, 64));
      endcase
      steady = (ph == STEADY_PHASE);
      random_items(PHASE_ITEMS);
    end

    drain();
    if (board.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #(50_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
